### hdl/co2_level_and_recal_qualifier_assert.svh
// Assertion macros used by the checker of the CO2 level and recalibration qualifier.
`ifndef CO2_LEVEL_AND_RECAL_QUALIFIER_ASSERT_SVH
`define CO2_LEVEL_AND_RECAL_QUALIFIER_ASSERT_SVH

// Same-cycle implication, switched off while reset is high.
`define CO2_ASSERT_IMPLY(label, clock, reset, cond, cons) \
  label: assert property (@(posedge clock) disable iff (reset) (cond) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, switched off while reset is high.
`define CO2_ASSERT_NEXT(label, clock, reset, cond, cons) \
  label: assert property (@(posedge clock) disable iff (reset) (cond) |=> (cons)) \
    else $error("assertion failed");

// Same-cycle implication that is checked through reset as well.
`define CO2_ASSERT_ALWAYS(label, clock, cond, cons) \
  label: assert property (@(posedge clock) (cond) |-> (cons)) \
    else $error("assertion failed");

`endif

### hdl/co2lrq_pkg.sv
// Codes, constants and the grading function of the CO2 level and recalibration qualifier.
package co2lrq_pkg;

  localparam int unsigned PPM_W    = 16;
  localparam int unsigned CAL_W    = 11;
  localparam int unsigned TICKS_W  = 6;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned LEVEL_W  = 2;
  localparam int unsigned OP_W     = 2;
  localparam int unsigned ADDR_W   = 5;
  localparam int unsigned DATA_W   = 32;

  // Operation codes of an input beat.
  localparam logic [OP_W-1:0] OP_TICK    = 2'd0;
  localparam logic [OP_W-1:0] OP_ARM     = 2'd1;
  localparam logic [OP_W-1:0] OP_DISARM  = 2'd2;
  localparam logic [OP_W-1:0] OP_RECAL   = 2'd3;

  // Status codes of a result beat.
  localparam logic [STATUS_W-1:0] STATUS_IDLE      = 3'd0;
  localparam logic [STATUS_W-1:0] STATUS_CHECKING  = 3'd1;
  localparam logic [STATUS_W-1:0] STATUS_CAL_NOW   = 3'd2;
  localparam logic [STATUS_W-1:0] STATUS_RANGE     = 3'd3;
  localparam logic [STATUS_W-1:0] STATUS_NOT_ARMED = 3'd4;
  localparam logic [STATUS_W-1:0] STATUS_UNSTABLE  = 3'd5;

  // Alert levels.
  localparam logic [LEVEL_W-1:0] LEVEL_GREEN  = 2'd0;
  localparam logic [LEVEL_W-1:0] LEVEL_YELLOW = 2'd1;
  localparam logic [LEVEL_W-1:0] LEVEL_RED    = 2'd2;
  localparam logic [LEVEL_W-1:0] LEVEL_BLINK  = 2'd3;

  // Register indexes on the configuration port.
  localparam logic [2:0] REG_YELLOW = 3'd0;
  localparam logic [2:0] REG_RED    = 3'd1;
  localparam logic [2:0] REG_BLINK  = 3'd2;
  localparam logic [2:0] REG_GRADE  = 3'd3;
  localparam logic [2:0] REG_START  = 3'd4;

  // Reset values of the registers.
  localparam logic [PPM_W-1:0] YELLOW_RESET = 16'd800;
  localparam logic [PPM_W-1:0] RED_RESET    = 16'd1000;
  localparam logic [PPM_W-1:0] BLINK_RESET  = 16'd1200;
  localparam logic [PPM_W-1:0] START_RESET  = 16'd400;

  // Recalibration limits and stability window.
  localparam logic [PPM_W-1:0]   CAL_LOW     = 16'd400;
  localparam logic [PPM_W-1:0]   CAL_HIGH    = 16'd2000;
  localparam logic [PPM_W:0]     FIRST_TOL   = 17'sd90;
  localparam logic [PPM_W:0]     STEP_TOL    = 17'sd30;
  localparam logic [TICKS_W-1:0] NEED_STABLE = 6'd60;
  localparam logic [TICKS_W-1:0] ARM_SPAN    = 6'd60;

  // Thresholds are tested in turn, whatever their relative order.
  function automatic logic [LEVEL_W-1:0] grade(input logic [PPM_W-1:0] v,
                                               input logic [PPM_W-1:0] yel,
                                               input logic [PPM_W-1:0] red,
                                               input logic [PPM_W-1:0] blk);
    logic [LEVEL_W-1:0] g;
    if (v < yel) begin
      g = LEVEL_GREEN;
    end else if (v < red) begin
      g = LEVEL_YELLOW;
    end else if (v < blk) begin
      g = LEVEL_RED;
    end else begin
      g = LEVEL_BLINK;
    end
    return g;
  endfunction

endpackage

### hdl/co2_level_and_recal_qualifier.sv
// Top level of the CO2 level grader with its guarded recalibration qualifier.
//
// Input channel (in_valid/in_ready) carries one beat per event: a tick with an
// optional sample, an arm or disarm of the recalibration window, or a
// recalibration request with a reference value. Every input beat produces
// exactly one result beat on the output channel (out_valid/out_ready) with the
// alert level, the qualifier status, the calibration value and the stored
// reading and running average.
// The state is updated and the result computed in the cycle a beat is taken;
// the result appears in the output register in the following cycle. One beat
// is taken per cycle while the receiver does not stall; the output register is
// the only stage, so a result that waits is replaced in the same cycle that it
// is taken, and in_ready follows !out_valid || out_ready.
// When the receiver stalls, the result is held and no new beat is taken.
// A synchronous reset empties the output register, reloads the registers with
// their defaults and sets reading and average to the start value of 400 ppm.
// Thresholds and grading mode are written over the APB-style port, which
// always answers at once; they are meant to change only while the block idles.
module co2_level_and_recal_qualifier (
  input  logic                                clk,
  input  logic                                rst,
  // Configuration port
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [co2lrq_pkg::ADDR_W-1:0]       paddr,
  input  logic [co2lrq_pkg::DATA_W-1:0]       pwdata,
  output logic [co2lrq_pkg::DATA_W-1:0]       prdata,
  output logic                                pready,
  // Input channel
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [co2lrq_pkg::OP_W-1:0]         op,
  input  logic                                sample_valid,
  input  logic [co2lrq_pkg::PPM_W-1:0]        sample_ppm,
  input  logic [co2lrq_pkg::PPM_W-1:0]        reference_ppm,
  // Output channel
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [co2lrq_pkg::LEVEL_W-1:0]      level,
  output logic [co2lrq_pkg::STATUS_W-1:0]     status,
  output logic [co2lrq_pkg::CAL_W-1:0]        cal_value,
  output logic [co2lrq_pkg::PPM_W-1:0]        reading_ppm,
  output logic [co2lrq_pkg::PPM_W-1:0]        average_ppm
);
  import co2lrq_pkg::*;

  // Configuration registers
  logic [PPM_W-1:0] yellow_threshold;
  logic [PPM_W-1:0] red_threshold;
  logic [PPM_W-1:0] blink_threshold;
  logic             grade_average;
  logic [PPM_W-1:0] start_value;

  // Qualifier state
  logic [PPM_W-1:0]   reading, reading_next;
  logic [PPM_W-1:0]   running_average, running_average_next;
  logic [TICKS_W-1:0] arm_ticks, arm_ticks_next;
  logic               checking, checking_next;
  logic [PPM_W-1:0]   first_reading, first_reading_next;
  logic [PPM_W-1:0]   previous_reading, previous_reading_next;
  logic [TICKS_W-1:0] stable_count, stable_count_next;
  logic [CAL_W-1:0]   held_reference, held_reference_next;

  // Result of the beat being taken
  logic [LEVEL_W-1:0]  level_next;
  logic [STATUS_W-1:0] status_next;
  logic [CAL_W-1:0]    cal_next;

  logic             cfg_write;
  logic [2:0]       cfg_index;
  logic             in_take;
  logic [PPM_W:0]   avg_sum;
  logic [PPM_W-1:0] avg_half;
  logic [PPM_W:0]   diff_first;
  logic [PPM_W:0]   diff_prev;
  logic             near_first;
  logic             near_prev;
  logic [TICKS_W-1:0] count_inc;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;
  assign cfg_index = paddr[ADDR_W-1:2];

  always_comb begin
    case (cfg_index)
      REG_YELLOW: prdata = {{(DATA_W-PPM_W){1'b0}}, yellow_threshold};
      REG_RED:    prdata = {{(DATA_W-PPM_W){1'b0}}, red_threshold};
      REG_BLINK:  prdata = {{(DATA_W-PPM_W){1'b0}}, blink_threshold};
      REG_GRADE:  prdata = {{(DATA_W-1){1'b0}}, grade_average};
      REG_START:  prdata = {{(DATA_W-PPM_W){1'b0}}, start_value};
      default:    prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      yellow_threshold <= YELLOW_RESET;
      red_threshold    <= RED_RESET;
      blink_threshold  <= BLINK_RESET;
      grade_average    <= 1'b1;
      start_value      <= START_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_YELLOW: yellow_threshold <= pwdata[PPM_W-1:0];
        REG_RED:    red_threshold    <= pwdata[PPM_W-1:0];
        REG_BLINK:  blink_threshold  <= pwdata[PPM_W-1:0];
        REG_GRADE:  grade_average    <= pwdata[0];
        REG_START:  start_value      <= pwdata[PPM_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign in_ready = !out_valid || out_ready;
  assign in_take  = in_valid && in_ready;

  assign avg_sum  = {1'b0, running_average} + {1'b0, reading};
  assign avg_half = avg_sum[PPM_W:1];

  // Stability is judged on signed differences, so a sample below the centre
  // does not wrap round to a large positive value.
  assign diff_first = {1'b0, sample_ppm} - {1'b0, first_reading};
  assign diff_prev  = {1'b0, sample_ppm} - {1'b0, previous_reading};
  assign near_first = ($signed(diff_first) > -$signed(FIRST_TOL)) &&
                      ($signed(diff_first) < $signed(FIRST_TOL));
  assign near_prev  = ($signed(diff_prev) > -$signed(STEP_TOL)) &&
                      ($signed(diff_prev) < $signed(STEP_TOL));
  assign count_inc  = stable_count + 1'b1;

  always_comb begin
    reading_next          = reading;
    running_average_next  = running_average;
    arm_ticks_next        = arm_ticks;
    checking_next         = checking;
    first_reading_next    = first_reading;
    previous_reading_next = previous_reading;
    stable_count_next     = stable_count;
    held_reference_next   = held_reference;
    status_next           = STATUS_IDLE;
    cal_next              = '0;
    level_next            = grade(grade_average ? running_average : reading,
                                  yellow_threshold, red_threshold, blink_threshold);

    if (checking) begin
      status_next = STATUS_CHECKING;
      if (op == OP_TICK && sample_valid) begin
        reading_next = sample_ppm;
        if (near_first && near_prev) begin
          previous_reading_next = sample_ppm;
          stable_count_next     = count_inc;
          if (count_inc >= NEED_STABLE) begin
            checking_next = 1'b0;
            status_next   = STATUS_CAL_NOW;
            cal_next      = held_reference;
          end
        end else begin
          checking_next = 1'b0;
          status_next   = STATUS_UNSTABLE;
        end
      end else if (op == OP_ARM) begin
        arm_ticks_next = ARM_SPAN;
      end else if (op == OP_DISARM) begin
        arm_ticks_next = '0;
      end
    end else begin
      case (op)
        OP_TICK: begin
          running_average_next = avg_half;
          // Grading sees the new average but the reading from before the sample.
          level_next = grade(grade_average ? avg_half : reading,
                             yellow_threshold, red_threshold, blink_threshold);
          if (sample_valid) begin
            reading_next = sample_ppm;
          end
          if (arm_ticks != '0) begin
            arm_ticks_next = arm_ticks - 1'b1;
          end
        end
        OP_ARM: begin
          arm_ticks_next = ARM_SPAN;
        end
        OP_DISARM: begin
          arm_ticks_next = '0;
        end
        OP_RECAL: begin
          if (reference_ppm < CAL_LOW || reference_ppm > CAL_HIGH) begin
            status_next = STATUS_RANGE;
          end else if (arm_ticks == '0) begin
            status_next = STATUS_NOT_ARMED;
          end else begin
            arm_ticks_next        = '0;
            checking_next         = 1'b1;
            first_reading_next    = reading;
            previous_reading_next = reading;
            stable_count_next     = '0;
            held_reference_next   = reference_ppm[CAL_W-1:0];
            status_next           = STATUS_CHECKING;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      reading          <= START_RESET;
      running_average  <= START_RESET;
      arm_ticks        <= '0;
      checking         <= 1'b0;
      first_reading    <= '0;
      previous_reading <= '0;
      stable_count     <= '0;
      held_reference   <= '0;
    end else if (in_take) begin
      reading          <= reading_next;
      running_average  <= running_average_next;
      arm_ticks        <= arm_ticks_next;
      checking         <= checking_next;
      first_reading    <= first_reading_next;
      previous_reading <= previous_reading_next;
      stable_count     <= stable_count_next;
      held_reference   <= held_reference_next;
    end
  end

  // Output register: control state is reset, payload is simply loaded.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_take) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      level       <= level_next;
      status      <= status_next;
      cal_value   <= cal_next;
      reading_ppm <= reading_next;
      average_ppm <= running_average_next;
    end
  end

endmodule

### hdl/co2lrq_checker.sv
// Port-level checker of the CO2 level and recalibration qualifier, with its bind.
`include "co2_level_and_recal_qualifier_assert.svh"

module co2lrq_checker (
  input logic                                clk,
  input logic                                rst,
  input logic                                in_ready,
  input logic                                out_valid,
  input logic                                out_ready,
  input logic [co2lrq_pkg::STATUS_W-1:0]     status,
  input logic [co2lrq_pkg::CAL_W-1:0]        cal_value,
  input logic [co2lrq_pkg::PPM_W-1:0]        reading_ppm,
  input logic [co2lrq_pkg::PPM_W-1:0]        average_ppm
);
  import co2lrq_pkg::*;

  // The output register is empty at an edge where reset was high before and is now low.
  `CO2_ASSERT_ALWAYS(a_empty_after_reset, clk, !rst && $past(rst), !out_valid)

  // An empty output register never holds back the input.
  `CO2_ASSERT_IMPLY(a_ready_when_empty, clk, rst, !out_valid, in_ready)

  // A calibration value is only shown with a successful check.
  `CO2_ASSERT_IMPLY(a_cal_only_on_success, clk, rst,
    out_valid && status != STATUS_CAL_NOW, cal_value == '0)

  // A stalled result beat keeps its status, reading and average.
  `CO2_ASSERT_NEXT(a_hold_on_stall, clk, rst, out_valid && !out_ready,
    out_valid && $stable(status) && $stable(reading_ppm) && $stable(average_ppm))

endmodule

bind co2_level_and_recal_qualifier co2lrq_checker u_co2lrq_checker (
  .clk         (clk),
  .rst         (rst),
  .in_ready    (in_ready),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .status      (status),
  .cal_value   (cal_value),
  .reading_ppm (reading_ppm),
  .average_ppm (average_ppm)
);

### tb/co2_level_and_recal_qualifier_test.sv
// Self-checking testbench for the CO2 level grader and recalibration qualifier.
module co2_level_and_recal_qualifier_test;
  import co2lrq_pkg::*;

  localparam int unsigned RUN_LIMIT_CYCLES = 400000;
  localparam int unsigned LONG_HOLD_CYCLES = 300;

  typedef struct packed {
    logic [LEVEL_W-1:0]  level;
    logic [STATUS_W-1:0] status;
    logic [CAL_W-1:0]    cal;
    logic [PPM_W-1:0]    reading;
    logic [PPM_W-1:0]    average;
  } co2_report_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [ADDR_W-1:0]   paddr = '0;
  logic [DATA_W-1:0]   pwdata = '0;
  logic [DATA_W-1:0]   prdata;
  logic                pready;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic [OP_W-1:0]     op = OP_TICK;
  logic                sample_valid = 1'b0;
  logic [PPM_W-1:0]    sample_ppm = '0;
  logic [PPM_W-1:0]    reference_ppm = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [LEVEL_W-1:0]  level;
  logic [STATUS_W-1:0] status;
  logic [CAL_W-1:0]    cal_value;
  logic [PPM_W-1:0]    reading_ppm;
  logic [PPM_W-1:0]    average_ppm;

  co2_level_and_recal_qualifier dut (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .in_valid(in_valid), .in_ready(in_ready), .op(op), .sample_valid(sample_valid),
    .sample_ppm(sample_ppm), .reference_ppm(reference_ppm),
    .out_valid(out_valid), .out_ready(out_ready), .level(level), .status(status),
    .cal_value(cal_value), .reading_ppm(reading_ppm), .average_ppm(average_ppm)
  );

  always #10 clk = ~clk;

  // Predicted copy of the registers and the qualifier state.
  logic [PPM_W-1:0]   m_yellow = YELLOW_RESET;
  logic [PPM_W-1:0]   m_red = RED_RESET;
  logic [PPM_W-1:0]   m_blink = BLINK_RESET;
  logic               m_grade_avg = 1'b1;
  logic [PPM_W-1:0]   m_start = START_RESET;
  logic [PPM_W-1:0]   m_reading = START_RESET;
  logic [PPM_W-1:0]   m_average = START_RESET;
  logic [TICKS_W-1:0] m_arm = '0;
  logic               m_checking = 1'b0;
  logic [PPM_W-1:0]   m_first = '0;
  logic [PPM_W-1:0]   m_prev = '0;
  logic [TICKS_W-1:0] m_stable = '0;
  logic [CAL_W-1:0]   m_held = '0;

  co2_report_t awaited_reports[$];
  int unsigned mismatches = 0;
  int unsigned events_sent = 0;
  int unsigned results_checked = 0;
  int unsigned cal_passed = 0;
  int unsigned cal_aborted = 0;
  int unsigned requests_refused = 0;
  int unsigned settings_used = 0;
  int unsigned burst_left = 0;
  bit          long_hold_req = 1'b0;

  function automatic logic [LEVEL_W-1:0] level_of(input logic [PPM_W-1:0] v);
    if (v < m_yellow) return LEVEL_GREEN;
    if (v < m_red) return LEVEL_YELLOW;
    if (v < m_blink) return LEVEL_RED;
    return LEVEL_BLINK;
  endfunction

  function automatic bit within_band(input int v, input int centre, input int tol);
    return v > centre - tol && v < centre + tol;
  endfunction

  function automatic logic coin();
    return 1'($urandom_range(0, 1));
  endfunction

  function automatic co2_report_t qualify_event(input logic [OP_W-1:0] kind,
                                                input logic with_sample,
                                                input logic [PPM_W-1:0] ppm,
                                                input logic [PPM_W-1:0] ref_ppm);
    co2_report_t r;
    logic [PPM_W:0] sum17;
    r.status = STATUS_IDLE;
    r.cal = '0;
    r.level = level_of(m_grade_avg ? m_average : m_reading);
    if (m_checking) begin
      r.status = STATUS_CHECKING;
      if (kind == OP_TICK && with_sample) begin
        m_reading = ppm;
        if (within_band(int'(ppm), int'(m_first), int'(FIRST_TOL)) &&
            within_band(int'(ppm), int'(m_prev), int'(STEP_TOL))) begin
          m_prev = ppm;
          m_stable = m_stable + 1'b1;
          if (m_stable >= NEED_STABLE) begin
            m_checking = 1'b0;
            r.status = STATUS_CAL_NOW;
            r.cal = m_held;
            cal_passed++;
          end
        end else begin
          m_checking = 1'b0;
          r.status = STATUS_UNSTABLE;
          cal_aborted++;
        end
      end else if (kind == OP_ARM) begin
        m_arm = ARM_SPAN;
      end else if (kind == OP_DISARM) begin
        m_arm = '0;
      end
    end else begin
      case (kind)
        OP_TICK: begin
          sum17 = {1'b0, m_average} + {1'b0, m_reading};
          m_average = sum17[PPM_W:1];
          r.level = level_of(m_grade_avg ? m_average : m_reading);
          if (with_sample) m_reading = ppm;
          if (m_arm != 0) m_arm = m_arm - 1'b1;
        end
        OP_ARM: m_arm = ARM_SPAN;
        OP_DISARM: m_arm = '0;
        default: begin
          if (ref_ppm < CAL_LOW || ref_ppm > CAL_HIGH) begin
            r.status = STATUS_RANGE;
            requests_refused++;
          end else if (m_arm == 0) begin
            r.status = STATUS_NOT_ARMED;
            requests_refused++;
          end else begin
            m_arm = '0;
            m_checking = 1'b1;
            m_first = m_reading;
            m_prev = m_reading;
            m_stable = '0;
            m_held = ref_ppm[CAL_W-1:0];
            r.status = STATUS_CHECKING;
          end
        end
      endcase
    end
    r.reading = m_reading;
    r.average = m_average;
    return r;
  endfunction

  function automatic logic [DATA_W-1:0] setting_word(input logic [2:0] idx);
    case (idx)
      REG_YELLOW: return DATA_W'(m_yellow);
      REG_RED:    return DATA_W'(m_red);
      REG_BLINK:  return DATA_W'(m_blink);
      REG_GRADE:  return DATA_W'(m_grade_avg);
      default:    return DATA_W'(m_start);
    endcase
  endfunction

  task automatic write_setting(input logic [2:0] idx, input logic [DATA_W-1:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_YELLOW: m_yellow = value[PPM_W-1:0];
      REG_RED:    m_red = value[PPM_W-1:0];
      REG_BLINK:  m_blink = value[PPM_W-1:0];
      REG_GRADE:  m_grade_avg = value[0];
      default:    m_start = value[PPM_W-1:0];
    endcase
    @(posedge clk);
  endtask

  task automatic check_setting(input logic [2:0] idx);
    logic [DATA_W-1:0] want_word;
    logic [DATA_W-1:0] got_word;
    want_word = setting_word(idx);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= {idx, 2'b00};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    got_word = prdata;
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    if (got_word !== want_word) begin
      mismatches++;
      if (mismatches <= 10)
        $display("register %0d read back %0h, expected %0h", idx, got_word, want_word);
    end
  endtask

  // The sender offers beats in bursts and idles for a random gap, at times none, between them.
  task automatic send_event(input logic [OP_W-1:0] kind, input logic with_sample,
                            input logic [PPM_W-1:0] ppm, input logic [PPM_W-1:0] ref_ppm);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    op <= kind;
    sample_valid <= with_sample;
    sample_ppm <= ppm;
    reference_ppm <= ref_ppm;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    awaited_reports.push_back(qualify_event(kind, with_sample, ppm, ref_ppm));
    events_sent++;
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (awaited_reports.size() != 0) @(posedge clk);
  endtask

  function automatic logic [PPM_W-1:0] pick_ppm();
    case ($urandom_range(0, 5))
      0:       return PPM_W'($urandom_range(0, 65535));
      1:       return PPM_W'($urandom_range(0, 120));
      2:       return PPM_W'($urandom_range(65415, 65535));
      default: return PPM_W'($urandom_range(0, 2500));
    endcase
  endfunction

  function automatic logic [PPM_W-1:0] pick_reference();
    if ($urandom_range(0, 1) == 0) return PPM_W'($urandom_range(350, 2050));
    return PPM_W'($urandom_range(0, 65535));
  endfunction

  task automatic send_random_event();
    int unsigned pick;
    logic [OP_W-1:0] kind;
    pick = $urandom_range(0, 9);
    if (pick < 6) kind = OP_TICK;
    else if (pick == 6) kind = OP_ARM;
    else if (pick == 7) kind = OP_DISARM;
    else kind = OP_RECAL;
    send_event(kind, coin(), pick_ppm(), pick_reference());
  endtask

  // A sample that stays within both tolerances of the check in progress.
  function automatic logic [PPM_W-1:0] steady_sample();
    int s;
    s = int'(m_prev) + int'($urandom_range(0, 58)) - 29;
    if (s < int'(m_first) - 89) s = int'(m_first) - 89;
    if (s > int'(m_first) + 89) s = int'(m_first) + 89;
    if (s < 0) s = 0;
    if (s > 65535) s = 65535;
    return PPM_W'(s);
  endfunction

  // A sample that breaks a tolerance: exactly on the step or window edge, or far off.
  function automatic logic [PPM_W-1:0] unsteady_sample();
    case ($urandom_range(0, 2))
      0:       return (m_prev >= 30) ? m_prev - 16'd30 : m_prev + 16'd30;
      1:       return (m_first >= 90) ? m_first - 16'd90 : m_first + 16'd90;
      default: return m_prev ^ 16'h8000;
    endcase
  endfunction

  task automatic attempt_calibration();
    int unsigned idle_ticks;
    int unsigned guard;
    int unsigned spoil_at;
    int unsigned sel;
    logic [PPM_W-1:0] ref_ppm;
    send_event(OP_TICK, 1'b1, pick_ppm(), pick_reference());
    send_event(OP_ARM, coin(), pick_ppm(), pick_reference());
    // Now and then the window is left to run close to or past its end before the request.
    idle_ticks = ($urandom_range(0, 7) == 0) ? $urandom_range(55, 66) : $urandom_range(0, 6);
    repeat (idle_ticks) send_event(OP_TICK, 1'b0, pick_ppm(), pick_reference());
    ref_ppm = ($urandom_range(0, 9) == 0) ? PPM_W'($urandom_range(0, 65535))
                                          : PPM_W'($urandom_range(400, 2000));
    send_event(OP_RECAL, coin(), pick_ppm(), ref_ppm);
    spoil_at = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 60) : 0;
    guard = 0;
    while (m_checking && guard < 100) begin
      guard++;
      sel = $urandom_range(0, 99);
      if (guard == spoil_at) send_event(OP_TICK, 1'b1, unsteady_sample(), pick_reference());
      else if (sel < 88) send_event(OP_TICK, 1'b1, steady_sample(), pick_reference());
      else if (sel < 91) send_event(OP_TICK, 1'b0, pick_ppm(), pick_reference());
      else if (sel < 94) send_event(OP_ARM, coin(), pick_ppm(), pick_reference());
      else if (sel < 97) send_event(OP_DISARM, coin(), pick_ppm(), pick_reference());
      else send_event(OP_RECAL, coin(), pick_ppm(), pick_reference());
    end
  endtask

  task automatic apply_thresholds(input logic [PPM_W-1:0] yel, input logic [PPM_W-1:0] red,
                                  input logic [PPM_W-1:0] blk, input logic grade_avg,
                                  input logic [PPM_W-1:0] start);
    logic [2:0] idx;
    drain_results();
    write_setting(REG_YELLOW, {PPM_W'($urandom), yel});
    write_setting(REG_RED, {PPM_W'($urandom), red});
    write_setting(REG_BLINK, {PPM_W'($urandom), blk});
    write_setting(REG_GRADE, {31'($urandom), grade_avg});
    write_setting(REG_START, {PPM_W'($urandom), start});
    for (int i = 0; i <= 4; i++) begin
      idx = 3'(i);
      check_setting(idx);
    end
    settings_used++;
  endtask

  task automatic test_register_defaults();
    logic [2:0] idx;
    for (int i = 0; i <= 4; i++) begin
      idx = 3'(i);
      check_setting(idx);
    end
  endtask

  task automatic test_directed_cases();
    send_event(OP_TICK, 1'b1, 16'hFFFF, 16'hFFFF);
    send_event(OP_TICK, 1'b0, 16'h0000, 16'h0000);
    send_event(OP_TICK, 1'b1, 16'h0000, 16'h0000);
    // References just outside the accepted band, then a request with no window.
    send_event(OP_RECAL, 1'b0, 16'd0, 16'd399);
    send_event(OP_RECAL, 1'b0, 16'd0, 16'd2001);
    send_event(OP_RECAL, 1'b1, 16'd0, 16'd400);
    send_event(OP_ARM, 1'b0, 16'd0, 16'd0);
    send_event(OP_DISARM, 1'b0, 16'd0, 16'd0);
    send_event(OP_RECAL, 1'b0, 16'd0, 16'd2000);
    send_event(OP_TICK, 1'b1, 16'd10, 16'd0);
    send_event(OP_ARM, 1'b0, 16'd0, 16'd0);
    // The range test wins over an open window.
    send_event(OP_RECAL, 1'b0, 16'd0, 16'd0);
    send_event(OP_RECAL, 1'b0, 16'd0, 16'd2000);
    send_event(OP_TICK, 1'b1, 16'd39, 16'd0);
    send_event(OP_ARM, 1'b0, 16'd0, 16'd0);
    send_event(OP_DISARM, 1'b0, 16'd0, 16'd0);
    send_event(OP_RECAL, 1'b0, 16'd0, 16'd1000);
    send_event(OP_TICK, 1'b0, 16'd500, 16'd0);
    // Close to zero as a signed 16-bit value, but far off as the zero-extended value that is compared.
    send_event(OP_TICK, 1'b1, 16'hFFFF, 16'd0);
    send_event(OP_ARM, 1'b0, 16'd0, 16'd0);
    send_event(OP_RECAL, 1'b0, 16'd0, 16'd1234);
    // A step of exactly the step tolerance aborts.
    send_event(OP_TICK, 1'b1, 16'd65505, 16'd0);
  endtask

  task automatic test_threshold_settings();
    logic [PPM_W-1:0] yel;
    logic [PPM_W-1:0] red;
    logic [PPM_W-1:0] blk;
    for (int phase = 0; phase < 8; phase++) begin
      case (phase)
        0: apply_thresholds(YELLOW_RESET, RED_RESET, BLINK_RESET, 1'b1, START_RESET);
        1: apply_thresholds(16'd0, 16'd0, 16'd0, 1'b0, 16'd0);
        2: apply_thresholds(16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1, 16'hFFFF);
        3: apply_thresholds(16'd1500, 16'd900, 16'd600, 1'b0, PPM_W'($urandom));
        4: apply_thresholds(16'd1000, 16'd1000, 16'd1000, 1'b1, PPM_W'($urandom));
        default: begin
          yel = PPM_W'($urandom_range(300, 1200));
          red = yel + PPM_W'($urandom_range(0, 600));
          blk = red + PPM_W'($urandom_range(0, 600));
          apply_thresholds(yel, red, blk, coin(), PPM_W'($urandom));
        end
      endcase
      repeat (70) send_random_event();
      attempt_calibration();
    end
  endtask

  // The receiver holds off for a long stretch while beats keep being offered.
  task automatic test_backpressure();
    long_hold_req = 1'b1;
    repeat (40) send_random_event();
    drain_results();
    attempt_calibration();
  endtask

  task automatic test_calibration_runs();
    for (int n = 0; n < 6; n++) begin
      repeat (10) send_random_event();
      attempt_calibration();
    end
  endtask

  // The receiver's stall pattern changes mode after stretches of random length.
  always begin
    int unsigned rx_left;
    int unsigned rx_mode;
    @(posedge clk);
    if (long_hold_req) begin
      out_ready <= 1'b0;
      repeat (LONG_HOLD_CYCLES) @(posedge clk);
      long_hold_req = 1'b0;
    end else begin
      if (rx_left == 0) begin
        rx_left = $urandom_range(5, 60);
        rx_mode = $urandom_range(0, 3);
      end
      rx_left--;
      case (rx_mode)
        0: out_ready <= 1'b1;
        1: out_ready <= ($urandom_range(0, 3) != 0);
        2: out_ready <= ($urandom_range(0, 3) == 0);
        default: out_ready <= rx_left[0];
      endcase
    end
  end

  always @(posedge clk) begin
    co2_report_t want;
    if (!rst && out_valid && out_ready) begin
      if (awaited_reports.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result beat: level %0d status %0d cal %0d reading %0d avg %0d",
                   level, status, cal_value, reading_ppm, average_ppm);
      end else begin
        want = awaited_reports.pop_front();
        results_checked++;
        if (want.level !== level || want.status !== status || want.cal !== cal_value ||
            want.reading !== reading_ppm || want.average !== average_ppm) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("result %0d: expected level %0d status %0d cal %0d reading %0d avg %0d",
                     results_checked, want.level, want.status, want.cal, want.reading,
                     want.average);
            $display("result %0d: got      level %0d status %0d cal %0d reading %0d avg %0d",
                     results_checked, level, status, cal_value, reading_ppm, average_ppm);
          end
        end
      end
    end
  end

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    test_register_defaults();
    test_directed_cases();
    test_threshold_settings();
    test_backpressure();
    test_calibration_runs();
    drain_results();
    repeat (8) @(posedge clk);
    $display("Sent %0d events and checked %0d results over %0d register settings.",
             events_sent, results_checked, settings_used);
    $display("Checks passed %0d, aborted %0d; %0d requests refused; %0d mismatches.",
             cal_passed, cal_aborted, requests_refused, mismatches);
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #(RUN_LIMIT_CYCLES * 20);
    $display("Run stopped by the time limit.");
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
